### sv/pedal_settle_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// pedal settle detector assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef PEDAL_SETTLE_DETECTOR_UNIT_ASSERT_SVH
`define PEDAL_SETTLE_DETECTOR_UNIT_ASSERT_SVH

// clocked property, switched off while reset is high
`define PSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds across reset
`define PSD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// shared types, register codes and helpers of the pedal settle detector
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int CFG_INDEX_W = 2;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MOVE_THRESHOLD   = 2'd0,
    REG_SETTLE_TOLERANCE = 2'd1
  } cfg_reg_t;

  localparam sample_t MOVE_THRESHOLD_RESET   = 12'd100;
  localparam sample_t SETTLE_TOLERANCE_RESET = 12'd10;

  // absolute difference of two samples
  function automatic sample_t distance(sample_t a, sample_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### sv/psd_if.sv
// ----------------------------------------------------------------------------
// psd stream interfaces
// valid/ready channels for sample beats in and settled beats out
// ----------------------------------------------------------------------------
interface psd_sample_if import psd_pkg::*; ;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface psd_flag_if;
  logic valid;
  logic ready;
  logic settled;

  modport source (output valid, output settled, input ready);
  modport sink (input valid, input settled, output ready);
endinterface

### sv/psd_ring.sv
// ----------------------------------------------------------------------------
// psd_ring
// ring of recent samples with running total and latched start value
// ----------------------------------------------------------------------------
module psd_ring import psd_pkg::*; #(
  parameter int RING_DEPTH = 16,
  parameter int TOTAL_W    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  sample_t            sample,
  output logic [TOTAL_W-1:0] total_next,
  output sample_t            start_ref
);

  localparam int SLOT_W = $clog2(RING_DEPTH);

  sample_t             mem [RING_DEPTH];
  sample_t             rd_data;
  sample_t             old_value;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   slot_next;
  logic [SLOT_W-1:0]   rd_addr;
  logic                ring_full;
  logic                start_valid;
  sample_t             start_sample;
  logic [TOTAL_W-1:0]  ring_total;

  // next slot, wrapping at the ring depth
  assign slot_next = (slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;

  // prefetch the entry the next beat will overwrite
  assign rd_addr = accept ? slot_next : slot;

  // entries not yet written since reset read as zero
  assign old_value  = ring_full ? rd_data : '0;
  assign total_next = ring_total - TOTAL_W'(old_value) + TOTAL_W'(sample);

  // first beat after reset is its own start value
  assign start_ref = start_valid ? start_sample : sample;

  // sample memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[slot] <= sample;
    end
    rd_data <= mem[rd_addr];
  end

  // ring pointer, fill flag, total and start value
  always_ff @(posedge clk) begin
    if (rst) begin
      slot         <= '0;
      ring_full    <= 1'b0;
      ring_total   <= '0;
      start_valid  <= 1'b0;
      start_sample <= '0;
    end else if (accept) begin
      slot       <= slot_next;
      ring_total <= total_next;
      if (slot == SLOT_W'(RING_DEPTH - 1)) begin
        ring_full <= 1'b1;
      end
      if (!start_valid) begin
        start_valid  <= 1'b1;
        start_sample <= sample;
      end
    end
  end

endmodule

### sv/psd_avg.sv
// ----------------------------------------------------------------------------
// psd_avg
// floor average of the ring total over the ring depth
// ----------------------------------------------------------------------------
module psd_avg import psd_pkg::*; #(
  parameter int RING_DEPTH = 16,
  parameter int TOTAL_W    = 16
) (
  input  logic [TOTAL_W-1:0] total,
  output sample_t            average
);

  localparam bit IS_POW2 = ((RING_DEPTH & (RING_DEPTH - 1)) == 0);
  localparam int DEPTH_LOG2 = $clog2(RING_DEPTH);

  if (IS_POW2) begin : g_shift
    // power-of-two depth is a plain shift
    assign average = SAMPLE_W'(total >> DEPTH_LOG2);
  end else begin : g_recip
    // rounded-up reciprocal, exact for every total that fits in TOTAL_W bits
    localparam int RECIP_SHIFT = TOTAL_W + DEPTH_LOG2;
    localparam int RECIP_W     = TOTAL_W + 2;
    localparam int PROD_W      = TOTAL_W + RECIP_W;
    localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + RING_DEPTH - 1) / RING_DEPTH;

    logic [PROD_W-1:0] product;

    assign product = PROD_W'(total) * PROD_W'(RECIP);
    assign average = SAMPLE_W'(product >> RECIP_SHIFT);
  end

endmodule

### sv/pedal_settle_detector_unit.sv
// A sample beat passes the stage one register, then the output register as a settled
// beat. One beat per cycle when not stalled; the ring update is a single add and subtract
// on the running total, with the memory's registered read port fetching the next slot ahead.
// Reset clears pointer, fill flag, total, start value and handshake state at once;
// unwritten ring slots read as zero through the fill flag, so no clearing pass runs.
// ----------------------------------------------------------------------------
// pedal_settle_detector_unit
// flags a sensor that has moved from its start value and settled near its
// recent average
// ----------------------------------------------------------------------------
module pedal_settle_detector_unit import psd_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  sample_t                cfg_data,
  psd_sample_if.sink             samples,
  psd_flag_if.source             flags
);

  localparam int TOTAL_W = $clog2(RING_DEPTH * ((1 << SAMPLE_W) - 1) + 1);

  sample_t            move_threshold;
  sample_t            settle_tolerance;
  logic               accept;
  logic               advance;
  logic [TOTAL_W-1:0] total_next;
  sample_t            start_ref;
  logic               moved;
  logic               st1_valid;
  sample_t            st1_sample;
  logic               st1_moved;
  logic [TOTAL_W-1:0] st1_total;
  sample_t            average;
  logic               settled_next;
  logic               out_valid;
  logic               out_settled;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold   <= MOVE_THRESHOLD_RESET;
      settle_tolerance <= SETTLE_TOLERANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_THRESHOLD:   move_threshold   <= cfg_data;
        REG_SETTLE_TOLERANCE: settle_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: stage one moves on whenever the output register is free
  assign advance       = !out_valid || flags.ready;
  assign samples.ready = !rst && (!st1_valid || advance);
  assign accept        = samples.valid && samples.ready;

  psd_ring #(
    .RING_DEPTH (RING_DEPTH),
    .TOTAL_W    (TOTAL_W)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .sample     (samples.sample),
    .total_next (total_next),
    .start_ref  (start_ref)
  );

  // moved far enough from the start value
  assign moved = (distance(samples.sample, start_ref) >= move_threshold);

  // stage one register
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (accept) begin
      st1_valid <= 1'b1;
    end else if (advance) begin
      st1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1_sample <= samples.sample;
      st1_moved  <= moved;
      st1_total  <= total_next;
    end
  end

  psd_avg #(
    .RING_DEPTH (RING_DEPTH),
    .TOTAL_W    (TOTAL_W)
  ) u_avg (
    .total   (st1_total),
    .average (average)
  );

  // steady near the ring average
  assign settled_next = st1_moved && (distance(st1_sample, average) < settle_tolerance);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_settled <= settled_next;
    end
  end

  assign flags.valid   = out_valid;
  assign flags.settled = out_settled;

endmodule

### sv/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// port-level checks of the pedal settle detector, bound to the top level
// ----------------------------------------------------------------------------
`include "pedal_settle_detector_unit_assert.svh"

module psd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_settled
);

  // a result beat is held until taken
  `PSD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

  // a stalled result keeps its flag
  `PSD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_settled), "stalled result changed")

  // input stalls only behind a stalled output
  `PSD_ASSERT(a_ready_stall, !in_ready |-> out_valid && !out_ready, "input stalled with output free")

  // a fresh result always comes from an input beat accepted through the stage one register
  `PSD_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without input beat")

endmodule

bind pedal_settle_detector_unit psd_checker u_psd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (flags.valid),
  .out_ready   (flags.ready),
  .out_settled (flags.settled)
);
